@@ src/read_coverage_depth_counter_assert.svh @@
// assertion macros shared by the checker
`ifndef READ_COVERAGE_DEPTH_COUNTER_ASSERT_SVH
`define READ_COVERAGE_DEPTH_COUNTER_ASSERT_SVH

// condition in the cycle after the trigger, quiet while reset is low
`define RCDC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("rcdc check failed on the following cycle");

// condition in the same cycle as the trigger, quiet while reset is low
`define RCDC_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("rcdc check failed in the same cycle");

`endif

@@ src/rcdc_pkg.sv @@
package rcdc_pkg;

    localparam int POS_W       = 32;
    localparam int LEN_W       = 14;
    localparam int DELTA_W     = 17;
    localparam int DEPTH_OUT_W = 16;
    // index fields are sized for the largest window supported
    localparam int IDX_W       = 20;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;

    localparam logic [1:0] CMD_READ = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_NEW  = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_LATE,
        OP_TICK,
        OP_CLEAR
    } t_opcode;

    typedef struct packed {
        t_opcode            code;
        logic [POS_W-1:0]   pos;
        logic [IDX_W-1:0]   idx_a;
        logic [IDX_W-1:0]   idx_b;
        logic               ovf;
    } t_op;

    typedef struct packed {
        logic clearing;
        logic clear_done;
    } t_bk_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_MOD,
        S_B_RD,
        S_B_MOD,
        S_T_MOD
    } t_bk_state;

endpackage

@@ src/rcdc_fifo.sv @@
module rcdc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcdc_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rcdc_pkg::t_op o_head
);
    import rcdc_pkg::*;

    t_op                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

@@ src/rcdc_front.sv @@
module rcdc_front #(
    parameter int WINDOW = 16384
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [1:0]                  i_cmd,
    input  logic [rcdc_pkg::POS_W-1:0]  i_read_start,
    input  logic [rcdc_pkg::LEN_W-1:0]  i_read_length,
    output logic                        o_in_stall,
    input  rcdc_pkg::t_bk_status        i_bk,
    input  logic                        i_fifo_full,
    output logic                        o_push,
    output rcdc_pkg::t_op               o_op
);
    import rcdc_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW - 1);
    localparam logic [AW:0]   WIN_W    = (AW+1)'(WINDOW);

    // position tracking
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [AW-1:0]    r_idx,  n_idx;
    logic             r_ovf,  n_ovf;
    logic             r_clr_wait, n_clr_wait;

    // classified item, waiting for a queue slot
    logic             r_s1_valid, n_s1_valid;
    t_opcode          r_s1_code,  n_s1_code;
    logic [POS_W-1:0] r_s1_pos,   n_s1_pos;
    logic [AW-1:0]    r_s1_cur,   n_s1_cur;
    logic [AW-1:0]    r_s1_off_s, n_s1_off_s;
    logic [AW-1:0]    r_s1_off_e, n_s1_off_e;
    logic             r_s1_ovf,   n_s1_ovf;

    logic             accept;
    logic             s1_free;
    logic [POS_W:0]   end_pos;
    logic [POS_W:0]   diff_e;
    logic [POS_W-1:0] diff_s;
    logic             rd_empty;
    logic             rd_done;
    logic             rd_far;
    logic             rd_late;
    logic [AW:0]      sum_a;
    logic [AW:0]      sum_b;
    logic [AW:0]      wrap_a;
    logic [AW:0]      wrap_b;

    assign s1_free    = !r_s1_valid || !i_fifo_full;
    assign o_in_stall = r_clr_wait || i_bk.clearing || !s1_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s1_valid && !i_fifo_full;

    assign end_pos  = {1'b0, i_read_start} + (POS_W+1)'(i_read_length);
    assign diff_e   = end_pos - {1'b0, r_pos};
    assign diff_s   = i_read_start - r_pos;
    assign rd_empty = (i_read_length == '0);
    assign rd_done  = (end_pos <= {1'b0, r_pos});
    assign rd_far   = (diff_e >= (POS_W+1)'(WINDOW));
    assign rd_late  = (i_read_start < r_pos);

    // slot index = (current slot + offset) mod window, both below the window
    assign sum_a  = {1'b0, r_s1_cur} + {1'b0, r_s1_off_s};
    assign sum_b  = {1'b0, r_s1_cur} + {1'b0, r_s1_off_e};
    assign wrap_a = (sum_a >= WIN_W) ? sum_a - WIN_W : sum_a;
    assign wrap_b = (sum_b >= WIN_W) ? sum_b - WIN_W : sum_b;

    always_comb begin
        o_op.code  = r_s1_code;
        o_op.pos   = r_s1_pos;
        o_op.idx_a = IDX_W'(wrap_a[AW-1:0]);
        o_op.idx_b = IDX_W'(wrap_b[AW-1:0]);
        o_op.ovf   = r_s1_ovf;
    end

    always_comb begin
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_ovf      = r_ovf;
        n_clr_wait = r_clr_wait && !i_bk.clear_done;
        n_s1_valid = r_s1_valid && !o_push;
        n_s1_code  = r_s1_code;
        n_s1_pos   = r_s1_pos;
        n_s1_cur   = r_s1_cur;
        n_s1_off_s = r_s1_off_s;
        n_s1_off_e = r_s1_off_e;
        n_s1_ovf   = r_s1_ovf;
        if (accept) begin
            n_s1_pos   = r_pos;
            n_s1_cur   = r_idx;
            n_s1_ovf   = r_ovf;
            n_s1_off_s = diff_s[AW-1:0];
            n_s1_off_e = diff_e[AW-1:0];
            case (i_cmd)
                CMD_READ: begin
                    if (!rd_empty && !rd_done) begin
                        if (rd_far) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_s1_valid = 1'b1;
                            n_s1_code  = rd_late ? OP_LATE : OP_READ;
                        end
                    end
                end
                CMD_TICK: begin
                    n_s1_valid = 1'b1;
                    n_s1_code  = OP_TICK;
                    n_s1_off_s = '0;
                    n_pos      = r_pos + 1'b1;
                    if (r_pos == '1 || r_idx == LAST_IDX) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                CMD_NEW: begin
                    n_s1_valid = 1'b1;
                    n_s1_code  = OP_CLEAR;
                    n_pos      = '0;
                    n_idx      = '0;
                    n_ovf      = 1'b0;
                    n_clr_wait = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_idx      <= '0;
            r_ovf      <= 1'b0;
            r_clr_wait <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_idx      <= n_idx;
            r_ovf      <= n_ovf;
            r_clr_wait <= n_clr_wait;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_code  <= n_s1_code;
        r_s1_pos   <= n_s1_pos;
        r_s1_cur   <= n_s1_cur;
        r_s1_off_s <= n_s1_off_s;
        r_s1_off_e <= n_s1_off_e;
        r_s1_ovf   <= n_s1_ovf;
    end

endmodule

@@ src/rcdc_back.sv @@
module rcdc_back #(
    parameter int WINDOW     = 16384,
    parameter int DEPTH_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  rcdc_pkg::t_op                     i_head,
    output logic                              o_pop,
    output rcdc_pkg::t_bk_status              o_bk,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rcdc_pkg::POS_W-1:0]        o_position,
    output logic [rcdc_pkg::DEPTH_OUT_W-1:0]  o_depth,
    output logic                              o_overflow
);
    import rcdc_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int SW = ((DEPTH_BITS > DELTA_W) ? DEPTH_BITS : DELTA_W) + 2;
    localparam logic [AW-1:0]         LAST_IDX  = AW'(WINDOW - 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam logic signed [DELTA_W-1:0] DELTA_HI = {1'b0, {(DELTA_W-1){1'b1}}};
    localparam logic signed [DELTA_W-1:0] DELTA_LO = {1'b1, {(DELTA_W-1){1'b0}}};
    localparam logic signed [DELTA_W-1:0] DELTA_ONE = {{(DELTA_W-1){1'b0}}, 1'b1};

    logic signed [DELTA_W-1:0] mem [WINDOW];
    logic signed [DELTA_W-1:0] r_rdata;
    logic                      mem_we;
    logic [AW-1:0]             mem_addr;
    logic signed [DELTA_W-1:0] mem_wdata;

    t_bk_state               r_state,    n_state;
    t_op                     r_op,       n_op;
    logic [DEPTH_BITS-1:0]   r_depth,    n_depth;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic                    r_out_valid, n_out_valid;
    logic [POS_W-1:0]        r_out_pos,   n_out_pos;
    logic [DEPTH_OUT_W-1:0]  r_out_depth, n_out_depth;
    logic                    r_out_ovf,   n_out_ovf;

    logic [DEPTH_BITS-1:0]             depth_inc;
    logic signed [SW-1:0]              tick_sum;
    logic [DEPTH_BITS-1:0]             tick_depth;
    logic [DEPTH_BITS+DEPTH_OUT_W-1:0] tick_depth_ext;
    logic signed [DELTA_W-1:0]         delta_inc;
    logic signed [DELTA_W-1:0]         delta_dec;
    logic                              clear_done;

    assign depth_inc = (r_depth == DEPTH_MAX) ? r_depth : r_depth + 1'b1;
    assign tick_sum  = $signed({{(SW-DEPTH_BITS){1'b0}}, r_depth})
                     + $signed({{(SW-DELTA_W){r_rdata[DELTA_W-1]}}, r_rdata});

    always_comb begin
        if (tick_sum[SW-1]) begin
            tick_depth = '0;
        end else if (tick_sum > $signed({{(SW-DEPTH_BITS){1'b0}}, DEPTH_MAX})) begin
            tick_depth = DEPTH_MAX;
        end else begin
            tick_depth = tick_sum[DEPTH_BITS-1:0];
        end
    end

    assign tick_depth_ext = {{DEPTH_OUT_W{1'b0}}, tick_depth};
    assign delta_inc = (r_rdata == DELTA_HI) ? r_rdata : r_rdata + DELTA_ONE;
    assign delta_dec = (r_rdata == DELTA_LO) ? r_rdata : r_rdata - DELTA_ONE;

    assign o_bk        = '{clearing: (r_state == S_CLEAR), clear_done: clear_done};
    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_depth     = r_out_depth;
    assign o_overflow  = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_depth     = r_depth;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_pos   = r_out_pos;
        n_out_depth = r_out_depth;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_addr    = r_op.idx_a[AW-1:0];
        mem_wdata   = '0;
        o_pop       = 1'b0;
        clear_done  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_IDX) begin
                    n_clr_addr = '0;
                    n_state    = S_IDLE;
                    clear_done = 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_op  = i_head;
                    case (i_head.code)
                        OP_READ: begin
                            mem_addr = i_head.idx_a[AW-1:0];
                            n_state  = S_A_MOD;
                        end
                        OP_LATE: begin
                            mem_addr = i_head.idx_b[AW-1:0];
                            n_depth  = depth_inc;
                            n_state  = S_B_MOD;
                        end
                        OP_TICK: begin
                            mem_addr = i_head.idx_a[AW-1:0];
                            n_state  = S_T_MOD;
                        end
                        OP_CLEAR: begin
                            n_depth    = '0;
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_A_MOD: begin
                mem_we    = 1'b1;
                mem_wdata = delta_inc;
                n_state   = S_B_RD;
            end
            S_B_RD: begin
                mem_addr = r_op.idx_b[AW-1:0];
                n_state  = S_B_MOD;
            end
            S_B_MOD: begin
                mem_we    = 1'b1;
                mem_addr  = r_op.idx_b[AW-1:0];
                mem_wdata = delta_dec;
                n_state   = S_IDLE;
            end
            S_T_MOD: begin
                // hold the read address so the slot data stays while output waits
                if (!r_out_valid || !i_out_stall) begin
                    mem_we      = 1'b1;
                    n_depth     = tick_depth;
                    n_out_valid = 1'b1;
                    n_out_pos   = r_op.pos;
                    n_out_depth = tick_depth_ext[DEPTH_OUT_W-1:0];
                    n_out_ovf   = r_op.ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_depth     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_out_pos   <= n_out_pos;
        r_out_depth <= n_out_depth;
        r_out_ovf   <= n_out_ovf;
    end

    // single-port delta store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

endmodule

@@ src/read_coverage_depth_counter.sv @@
// path: a tick item passes the front register, queue, store read register and output register
// throughput: the single-port delta store sets it: an in-window read uses S_IDLE, S_A_MOD,
//   S_B_RD, S_B_MOD, a late read S_IDLE, S_B_MOD, a tick S_IDLE, S_T_MOD, a dropped read
//   none; the front takes 1 item per cycle, outside clearing, until the 4-entry queue fills
// reset and new chromosome: a clearing pass over all WINDOW slots (16384 by default) zeroes
//   the delta store, stalling input meanwhile; position, depth and overflow return to zero
module read_coverage_depth_counter #(
    parameter int WINDOW     = 16384,
    parameter int DEPTH_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_cmd,
    input  logic [rcdc_pkg::POS_W-1:0]        i_read_start,
    input  logic [rcdc_pkg::LEN_W-1:0]        i_read_length,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rcdc_pkg::POS_W-1:0]        o_position,
    output logic [rcdc_pkg::DEPTH_OUT_W-1:0]  o_depth,
    output logic                              o_overflow
);
    import rcdc_pkg::*;

    // front -> queue -> back
    t_op        front_op;
    logic       front_push;
    logic       fifo_full;
    logic       fifo_empty;
    t_op        fifo_head;
    logic       back_pop;
    t_bk_status bk_status;

    // front end: owns the current position, slot index and overflow flag,
    // classifies reads (dropped, too far, late, normal) and turns each kept
    // item into a store operation with its slot indexes resolved
    rcdc_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_cmd         (i_cmd),
        .i_read_start  (i_read_start),
        .i_read_length (i_read_length),
        .o_in_stall    (o_in_stall),
        .i_bk          (bk_status),
        .i_fifo_full   (fifo_full),
        .o_push        (front_push),
        .o_op          (front_op)
    );

    // short operation queue so each side stalls on its own
    rcdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_op    (front_op),
        .o_full  (fifo_full),
        .i_pop   (back_pop),
        .o_empty (fifo_empty),
        .o_head  (fifo_head)
    );

    // back end: delta store read-modify-writes, running depth, clearing
    // sweep and the output register
    rcdc_back #(
        .WINDOW     (WINDOW),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_head      (fifo_head),
        .o_pop       (back_pop),
        .o_bk        (bk_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_depth     (o_depth),
        .o_overflow  (o_overflow)
    );

endmodule

@@ src/rcdc_checker.sv @@
`include "read_coverage_depth_counter_assert.svh"

module rcdc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [1:0]                        i_cmd,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [rcdc_pkg::POS_W-1:0]        o_position,
    input logic [rcdc_pkg::DEPTH_OUT_W-1:0]  o_depth,
    input logic                              o_overflow
);
    import rcdc_pkg::*;

    // a stalled result holds
    `RCDC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_position) && $stable(o_depth) && $stable(o_overflow))

    // a new chromosome blocks input while the store is cleared
    `RCDC_ASSERT_NEXT(a_new_stalls, i_in_valid && !o_in_stall && i_cmd == CMD_NEW, o_in_stall)

    // the clearing pass after reset blocks input
    `RCDC_ASSERT_NOW(a_reset_stalls, $rose(i_rst_n), o_in_stall)

endmodule

bind read_coverage_depth_counter rcdc_checker u_rcdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_cmd         (i_cmd),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_position    (o_position),
    .o_depth       (o_depth),
    .o_overflow    (o_overflow)
);
